[hdl/bldr_pkg.sv]
// Shared constants for the breathing LED duty ramp.
// Register indexes, field widths, divider and scaling sizes.
// No dependencies.
package bldr_pkg;

	localparam int PERIOD_W   = 16;
	localparam int PCT_W      = 7;
	localparam int INTERVAL_W = 10;
	localparam int CMP_W      = 16;
	localparam int STAMP_W    = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Step divider: dividend covers range * update interval
	localparam int DIVIDEND_W = PCT_W + INTERVAL_W;
	localparam int DIVISOR_W  = 16;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
	localparam int STEP_W     = DIVIDEND_W;

	// Percent scaling by reciprocal multiplication: ceil(2^30 / 100) gives the
	// exact quotient for every duty * compare_period product below 2^23.
	localparam int PROD_W       = PCT_W + CMP_W;
	localparam int RECIP_W      = 24;
	localparam int RECIP_SHIFT  = 30;
	localparam int RECIP_PROD_W = PROD_W + RECIP_W;
	localparam int SCALED_W     = RECIP_PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

	localparam logic [DIVISOR_W-1:0] PCT_SCALE = DIVISOR_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_BREATH_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTVL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COMPARE_PER   = 3'd4;

	localparam logic [PERIOD_W-1:0]   RST_BREATH_PERIOD = 16'd2000;
	localparam logic [PCT_W-1:0]      RST_MIN_DUTY      = 7'd10;
	localparam logic [PCT_W-1:0]      RST_MAX_DUTY      = 7'd90;
	localparam logic [INTERVAL_W-1:0] RST_UPDATE_INTVL  = 10'd20;
	localparam logic [CMP_W-1:0]      RST_COMPARE_PER   = 16'd1000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[hdl/bldr_div.sv]
// Restoring divider, one quotient bit per cycle.
// Computes the duty step from the range, interval and half period.
// Depends on bldr_pkg.
module bldr_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [bldr_pkg::DIVIDEND_W-1:0]      dividend,
	input  logic [bldr_pkg::DIVISOR_W-1:0]       divisor,
	output logic [bldr_pkg::DIVIDEND_W-1:0]      quotient,
	output bldr_pkg::div_status_t                status
);

	localparam logic [bldr_pkg::DIV_CNT_W-1:0] LAST_CNT =
		bldr_pkg::DIV_CNT_W'(bldr_pkg::DIVIDEND_W - 1);

	logic [bldr_pkg::DIVISOR_W-1:0]  rem_q;
	logic [bldr_pkg::DIVIDEND_W-1:0] quo_q;
	logic [bldr_pkg::DIVISOR_W-1:0]  div_q;
	logic [bldr_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [bldr_pkg::DIVISOR_W:0] trial;
	logic [bldr_pkg::DIVISOR_W:0] diff;
	logic                         fits;

	always_comb begin
		trial = {rem_q, quo_q[bldr_pkg::DIVIDEND_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? diff[bldr_pkg::DIVISOR_W-1:0] : trial[bldr_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[bldr_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_start_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == '0))
		else $error("divider did not restart on start");

endmodule

[hdl/breathing_led_duty_ramp.sv]
// Breathing LED duty ramp: timestamp in, PWM compare value out.
// Flow: an accepted timestamp is checked against the update interval; an update then runs
// a step divide (start, iterations, done), a registered multiply and a scaling step.
// One transaction at a time; a timestamp inside the update interval returns to idle
// without an update; a held result stalls the output state.
// Reset: registers take their defaults, duty 0, direction rising, stamp 0.
// Depends on bldr_pkg and bldr_div.
module breathing_led_duty_ramp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bldr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bldr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bldr_pkg::STAMP_W-1:0]       now_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bldr_pkg::CMP_W-1:0]         pwm_compare,
	output logic [bldr_pkg::PCT_W-1:0]         duty_pct,
	output logic                               rising
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PREP,
		ST_DIV_STEP,
		ST_SCALE,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [bldr_pkg::PERIOD_W-1:0]   period_q;
	logic [bldr_pkg::PCT_W-1:0]      min_q;
	logic [bldr_pkg::PCT_W-1:0]      max_q;
	logic [bldr_pkg::INTERVAL_W-1:0] intvl_q;
	logic [bldr_pkg::CMP_W-1:0]      cmp_per_q;

	logic [bldr_pkg::STAMP_W-1:0] now_q;
	logic [bldr_pkg::STAMP_W-1:0] last_q;
	logic [bldr_pkg::PCT_W-1:0]   duty_q;
	logic                         ramp_q;
	logic [bldr_pkg::PROD_W-1:0]  prod_q;

	logic [bldr_pkg::CMP_W-1:0]   out_cmp_q;
	logic [bldr_pkg::PCT_W-1:0]   out_duty_q;
	logic                         out_rising_q;
	logic                         out_valid_q;

	logic [bldr_pkg::STAMP_W-1:0]      elapsed;
	logic [bldr_pkg::PCT_W-1:0]        range;
	logic [bldr_pkg::DIVISOR_W-2:0]    half;
	logic                              div_start;
	logic [bldr_pkg::DIVIDEND_W-1:0]   div_dividend;
	logic [bldr_pkg::DIVISOR_W-1:0]    div_divisor;
	logic [bldr_pkg::DIVIDEND_W-1:0]   div_quotient;
	bldr_pkg::div_status_t             div_status;
	logic [bldr_pkg::STEP_W-1:0]       step;
	logic [bldr_pkg::STEP_W:0]         up_sum;
	logic [bldr_pkg::STEP_W:0]         down_lim;
	logic [bldr_pkg::RECIP_PROD_W-1:0] recip_prod;
	logic [bldr_pkg::SCALED_W-1:0]     scaled;
	logic                              out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		elapsed  = now_q - last_q;
		range    = (max_q > min_q) ? (max_q - min_q) : '0;
		half     = period_q[bldr_pkg::PERIOD_W-1:1];
		if (half == '0) begin
			half = 15'd1;
		end
		step     = div_quotient[bldr_pkg::STEP_W-1:0];
		up_sum   = {{(bldr_pkg::STEP_W+1-bldr_pkg::PCT_W){1'b0}}, duty_q}
			+ {1'b0, step};
		down_lim = {{(bldr_pkg::STEP_W+1-bldr_pkg::PCT_W){1'b0}}, min_q}
			+ {1'b0, step};

		// divide by 100 as a multiply by the scaled reciprocal, keep the high bits
		recip_prod = {{bldr_pkg::RECIP_W{1'b0}}, prod_q}
			* {{bldr_pkg::PROD_W{1'b0}}, bldr_pkg::RECIP_100};
		scaled     = recip_prod[bldr_pkg::RECIP_PROD_W-1:bldr_pkg::RECIP_SHIFT];

		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_PREP: begin
				div_start    = 1'b1;
				div_dividend = {{(bldr_pkg::DIVIDEND_W-bldr_pkg::PCT_W){1'b0}}, range}
					* {{(bldr_pkg::DIVIDEND_W-bldr_pkg::INTERVAL_W){1'b0}}, intvl_q};
				div_divisor  = {1'b0, half};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bldr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.status   (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= bldr_pkg::RST_BREATH_PERIOD;
			min_q     <= bldr_pkg::RST_MIN_DUTY;
			max_q     <= bldr_pkg::RST_MAX_DUTY;
			intvl_q   <= bldr_pkg::RST_UPDATE_INTVL;
			cmp_per_q <= bldr_pkg::RST_COMPARE_PER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bldr_pkg::REG_BREATH_PERIOD: period_q  <= cfg_data;
				bldr_pkg::REG_MIN_DUTY:      min_q     <= cfg_data[bldr_pkg::PCT_W-1:0];
				bldr_pkg::REG_MAX_DUTY:      max_q     <= cfg_data[bldr_pkg::PCT_W-1:0];
				bldr_pkg::REG_UPDATE_INTVL:  intvl_q   <= cfg_data[bldr_pkg::INTERVAL_W-1:0];
				bldr_pkg::REG_COMPARE_PER:   cmp_per_q <= cfg_data;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			last_q      <= '0;
			duty_q      <= '0;
			ramp_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						now_q   <= now_ms;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (elapsed < {{(bldr_pkg::STAMP_W-bldr_pkg::INTERVAL_W){1'b0}}, intvl_q}) begin
						state_q <= ST_IDLE;
					end else begin
						last_q  <= now_q;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV_STEP;
				end
				ST_DIV_STEP: begin
					if (div_status.done) begin
						if (ramp_q) begin
							if (up_sum >= {{(bldr_pkg::STEP_W+1-bldr_pkg::PCT_W){1'b0}}, max_q}) begin
								duty_q <= max_q;
								ramp_q <= 1'b0;
							end else begin
								duty_q <= up_sum[bldr_pkg::PCT_W-1:0];
							end
						end else begin
							if ({{(bldr_pkg::STEP_W+1-bldr_pkg::PCT_W){1'b0}}, duty_q} <= down_lim) begin
								duty_q <= min_q;
								ramp_q <= 1'b1;
							end else begin
								duty_q <= duty_q - step[bldr_pkg::PCT_W-1:0];
							end
						end
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			prod_q <= {{(bldr_pkg::PROD_W-bldr_pkg::PCT_W){1'b0}}, duty_q}
				* {{(bldr_pkg::PROD_W-bldr_pkg::CMP_W){1'b0}}, cmp_per_q};
		end
		if (out_load) begin
			out_cmp_q <= (scaled[bldr_pkg::SCALED_W-1:bldr_pkg::CMP_W] != '0)
				? '1 : scaled[bldr_pkg::CMP_W-1:0];
			out_duty_q   <= duty_q;
			out_rising_q <= ramp_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pwm_compare = out_cmp_q;
	assign duty_pct    = out_duty_q;
	assign rising      = out_rising_q;

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result loaded outside the output state");

	a_div_only_in_div_states: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.busy |-> (state_q == ST_DIV_STEP))
		else $error("divider running outside the divide state");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CHECK))
		else $error("accepted transaction not checked next cycle");

	a_duty_in_bounds_after_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE && $past(ramp_q) && !ramp_q) |-> (duty_q == max_q))
		else $error("turn at the top did not clamp to the maximum");

endmodule

[tb/sv/breathing_led_duty_ramp_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the breathing LED duty ramp: watches the register, timestamp and result
// channels, predicts each duty update and compares it field by field with the block output.
// Depends on bldr_pkg.
module breathing_led_duty_ramp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [bldr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bldr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [bldr_pkg::STAMP_W-1:0]    now_ms,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [bldr_pkg::CMP_W-1:0]      pwm_compare,
	input  logic [bldr_pkg::PCT_W-1:0]      duty_pct,
	input  logic                            rising,
	output int                              mismatches,
	output int                              outstanding
);

	typedef struct packed {
		logic [bldr_pkg::CMP_W-1:0] pwm_compare;
		logic [bldr_pkg::PCT_W-1:0] duty_pct;
		logic                       rising;
	} ramp_result_t;

	logic [bldr_pkg::PERIOD_W-1:0]   period_reg;
	logic [bldr_pkg::PCT_W-1:0]      min_reg;
	logic [bldr_pkg::PCT_W-1:0]      max_reg;
	logic [bldr_pkg::INTERVAL_W-1:0] interval_reg;
	logic [bldr_pkg::CMP_W-1:0]      cmp_period_reg;

	logic [bldr_pkg::STAMP_W-1:0]    last_stamp;
	logic [bldr_pkg::PCT_W-1:0]      duty_level;
	logic                            ramp_rising;

	ramp_result_t pending_updates[$];
	ramp_result_t next_result;
	ramp_result_t oldest;

	// Advance the ramp for one timestamp; returns 1 when an update is due.
	function automatic bit ramp_update(input logic [bldr_pkg::STAMP_W-1:0] stamp,
			output ramp_result_t res);
		logic [31:0] elapsed;
		logic [31:0] span;
		logic [31:0] half;
		logic [31:0] step;
		logic [31:0] level;
		logic [31:0] scaled;
		elapsed = stamp - last_stamp;
		res = '0;
		if (elapsed < 32'(interval_reg))
			return 1'b0;
		last_stamp = stamp;

		span = (max_reg > min_reg) ? 32'(max_reg) - 32'(min_reg) : 32'd0;
		half = 32'(period_reg) / 32'd2;
		if (half == 32'd0)
			half = 32'd1;
		step = span * 32'(interval_reg) / half;

		level = 32'(duty_level);
		if (ramp_rising) begin
			if (level + step >= 32'(max_reg)) begin
				level = 32'(max_reg);
				ramp_rising = 1'b0;
			end else begin
				level = level + step;
			end
		end else begin
			if (level <= 32'(min_reg) + step) begin
				level = 32'(min_reg);
				ramp_rising = 1'b1;
			end else begin
				level = level - step;
			end
		end
		duty_level = level[bldr_pkg::PCT_W-1:0];

		scaled = 32'(duty_level) * 32'(cmp_period_reg) / 32'(bldr_pkg::PCT_SCALE);
		res.pwm_compare = (scaled > 32'h0000_FFFF) ? '1 : scaled[bldr_pkg::CMP_W-1:0];
		res.duty_pct = duty_level;
		res.rising = ramp_rising;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_reg = bldr_pkg::RST_BREATH_PERIOD;
			min_reg = bldr_pkg::RST_MIN_DUTY;
			max_reg = bldr_pkg::RST_MAX_DUTY;
			interval_reg = bldr_pkg::RST_UPDATE_INTVL;
			cmp_period_reg = bldr_pkg::RST_COMPARE_PER;
			last_stamp = '0;
			duty_level = '0;
			ramp_rising = 1'b1;
			pending_updates.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// keep only the register's width; spare indexes do nothing
				case (cfg_index)
					bldr_pkg::REG_BREATH_PERIOD:
						period_reg = cfg_data[bldr_pkg::PERIOD_W-1:0];
					bldr_pkg::REG_MIN_DUTY:
						min_reg = cfg_data[bldr_pkg::PCT_W-1:0];
					bldr_pkg::REG_MAX_DUTY:
						max_reg = cfg_data[bldr_pkg::PCT_W-1:0];
					bldr_pkg::REG_UPDATE_INTVL:
						interval_reg = cfg_data[bldr_pkg::INTERVAL_W-1:0];
					bldr_pkg::REG_COMPARE_PER:
						cmp_period_reg = cfg_data[bldr_pkg::CMP_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (pending_updates.size() == 0) begin
					mismatches++;
					$error("unexpected result: pwm_compare %0d duty_pct %0d rising %0d",
						pwm_compare, duty_pct, rising);
				end else begin
					oldest = pending_updates.pop_front();
					if (pwm_compare !== oldest.pwm_compare) begin
						mismatches++;
						$error("pwm_compare: expected %0d, got %0d",
							oldest.pwm_compare, pwm_compare);
					end
					if (duty_pct !== oldest.duty_pct) begin
						mismatches++;
						$error("duty_pct: expected %0d, got %0d", oldest.duty_pct, duty_pct);
					end
					if (rising !== oldest.rising) begin
						mismatches++;
						$error("rising: expected %0d, got %0d", oldest.rising, rising);
					end
				end
			end

			if (in_valid && in_ready) begin
				if (ramp_update(now_ms, next_result))
					pending_updates.push_back(next_result);
			end
			outstanding = pending_updates.size();
		end
	end

endmodule

[tb/sv/breathing_led_duty_ramp_tb.sv]
`timescale 1ns / 100ps
// Top of the breathing LED duty ramp testbench: clock, reset, register writes, timestamp
// stimulus and result back-pressure; checking is done by breathing_led_duty_ramp_checker.
// Depends on bldr_pkg, breathing_led_duty_ramp and the checker.
module breathing_led_duty_ramp_tb;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 80;
	localparam int TAIL_CYCLES   = 100;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_STAMPS  = 165;
	localparam int TAIL_STAMPS   = 150;

	localparam logic [bldr_pkg::CFG_IDX_W-1:0] IDX_SPARE_FIRST = 3'd5;
	localparam logic [bldr_pkg::CFG_IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [bldr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bldr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [bldr_pkg::STAMP_W-1:0]    now_ms;
	logic                            out_valid;
	logic                            out_ready;
	logic [bldr_pkg::CMP_W-1:0]      pwm_compare;
	logic [bldr_pkg::PCT_W-1:0]      duty_pct;
	logic                            rising;

	int mismatches;
	int outstanding;
	bit quiet_tail;

	logic [bldr_pkg::INTERVAL_W-1:0] cur_interval;
	logic [bldr_pkg::STAMP_W-1:0]    stamp_cursor;

	breathing_led_duty_ramp uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pwm_compare(pwm_compare),
		.duty_pct(duty_pct),
		.rising(rising)
	);

	breathing_led_duty_ramp_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pwm_compare(pwm_compare),
		.duty_pct(duty_pct),
		.rising(rising),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL breathing_led_duty_ramp");
		$finish;
	end

	// Result back-pressure: random stall bursts, none in the tail.
	initial begin
		int hold;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 13);
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			hold = $urandom_range(1, 40);
			repeat (hold) @(posedge clk);
		end
	end

	// Hold valid across back-to-back transactions; drop it only for a gap.
	task automatic send_stamp(input logic [bldr_pkg::STAMP_W-1:0] stamp);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= stamp;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic hold_until_drained(input int extra);
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bldr_pkg::CFG_IDX_W-1:0] idx,
			input logic [bldr_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Program all registers, with junk in the unused upper bits and a spare index write.
	task automatic program_ramp(input logic [bldr_pkg::PERIOD_W-1:0] period,
			input logic [bldr_pkg::PCT_W-1:0] min_pct,
			input logic [bldr_pkg::PCT_W-1:0] max_pct,
			input logic [bldr_pkg::INTERVAL_W-1:0] interval,
			input logic [bldr_pkg::CMP_W-1:0] cmp_period);
		logic [bldr_pkg::CFG_DATA_W-1:0] junk;
		junk = bldr_pkg::CFG_DATA_W'($urandom());
		write_reg(bldr_pkg::CFG_IDX_W'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
			bldr_pkg::CFG_DATA_W'($urandom()));
		write_reg(bldr_pkg::REG_BREATH_PERIOD, period);
		write_reg(bldr_pkg::REG_MIN_DUTY,
			{junk[bldr_pkg::CFG_DATA_W-1:bldr_pkg::PCT_W], min_pct});
		write_reg(bldr_pkg::REG_MAX_DUTY,
			{~junk[bldr_pkg::CFG_DATA_W-1:bldr_pkg::PCT_W], max_pct});
		write_reg(bldr_pkg::REG_UPDATE_INTVL,
			{junk[bldr_pkg::CFG_DATA_W-1:bldr_pkg::INTERVAL_W], interval});
		write_reg(bldr_pkg::REG_COMPARE_PER, cmp_period);
		cfg_valid <= 1'b0;
		cur_interval = interval;
	endtask

	// Mostly forward steps around the update interval, with some jumps back and noise.
	task automatic run_stamps(input int count);
		for (int k = 0; k < count; k++) begin
			if (k == count / 2)
				hold_until_drained(0);
			case ($urandom_range(0, 19))
				0:       stamp_cursor = $urandom();
				1:       stamp_cursor = stamp_cursor - $urandom_range(1, 50);
				default: stamp_cursor = stamp_cursor
						+ $urandom_range(0, 2 * int'(cur_interval) + 1);
			endcase
			send_stamp(stamp_cursor);
		end
	endtask

	initial begin
		logic [bldr_pkg::PERIOD_W-1:0]   period;
		logic [bldr_pkg::PCT_W-1:0]      min_pct;
		logic [bldr_pkg::PCT_W-1:0]      max_pct;
		logic [bldr_pkg::INTERVAL_W-1:0] interval;
		logic [bldr_pkg::CMP_W-1:0]      cmp_period;
		quiet_tail = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		now_ms <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= bldr_pkg::REG_BREATH_PERIOD;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: interval boundary and wrap of the timestamp
		cur_interval = bldr_pkg::RST_UPDATE_INTVL;
		send_stamp(32'h0000_0000);
		send_stamp(32'h0000_0013);
		send_stamp(32'h0000_0014);
		send_stamp(32'hFFFF_FFFF);
		send_stamp(32'h0000_0012);
		send_stamp(32'h0000_0013);

		// Period below two, percent above 100, compare saturation
		hold_until_drained(SETTLE_CYCLES);
		program_ramp(16'd1, 7'd0, 7'd127, 10'd1023, 16'hFFFF);
		send_stamp(32'h0000_0412);
		send_stamp(32'h0000_0811);
		send_stamp(32'h0000_0C10);

		// Min above max, zero interval, zero periods
		hold_until_drained(SETTLE_CYCLES);
		program_ramp(16'd0, 7'd127, 7'd0, 10'd0, 16'd0);
		send_stamp(32'h8000_0000);
		send_stamp(32'h8000_0000);
		send_stamp(32'h7FFF_FFFF);
		send_stamp(32'h5555_5555);

		for (int phase = 0; phase <= RANDOM_PHASES; phase++) begin
			hold_until_drained(SETTLE_CYCLES);
			case ($urandom_range(0, 5))
				0:       period = bldr_pkg::PERIOD_W'($urandom_range(0, 3));
				1:       period = bldr_pkg::PERIOD_W'($urandom_range(2, 200));
				2:       period = bldr_pkg::PERIOD_W'($urandom_range(200, 60000));
				3:       period = 16'd60000;
				4:       period = 16'hFFFF;
				default: period = bldr_pkg::PERIOD_W'($urandom());
			endcase
			case ($urandom_range(0, 5))
				0:       min_pct = 7'd0;
				1:       min_pct = 7'd100;
				2:       min_pct = bldr_pkg::PCT_W'($urandom());
				default: min_pct = bldr_pkg::PCT_W'($urandom_range(0, 50));
			endcase
			case ($urandom_range(0, 5))
				0:       max_pct = 7'd100;
				1:       max_pct = 7'd127;
				2:       max_pct = bldr_pkg::PCT_W'($urandom());
				default: max_pct = bldr_pkg::PCT_W'($urandom_range(50, 100));
			endcase
			case ($urandom_range(0, 7))
				0:       interval = 10'd0;
				1:       interval = 10'd1;
				2:       interval = 10'd1000;
				3:       interval = 10'd1023;
				4:       interval = bldr_pkg::INTERVAL_W'($urandom_range(1, 1000));
				default: interval = bldr_pkg::INTERVAL_W'($urandom_range(1, 50));
			endcase
			case ($urandom_range(0, 4))
				0:       cmp_period = 16'd0;
				1:       cmp_period = 16'hFFFF;
				2:       cmp_period = 16'd1000;
				default: cmp_period = bldr_pkg::CMP_W'($urandom());
			endcase
			program_ramp(period, min_pct, max_pct, interval, cmp_period);
			if ($urandom_range(0, 3) == 0)
				stamp_cursor = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			else
				stamp_cursor = $urandom();
			if (phase == RANDOM_PHASES) begin
				quiet_tail = 1'b1;
				run_stamps(TAIL_STAMPS);
			end else begin
				run_stamps(PHASE_STAMPS);
			end
		end

		hold_until_drained(TAIL_CYCLES);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS breathing_led_duty_ramp");
		else
			$display("FAIL breathing_led_duty_ramp");
		$finish;
	end

endmodule

[files.f]
hdl/bldr_pkg.sv
hdl/bldr_div.sv
hdl/breathing_led_duty_ramp.sv
tb/sv/breathing_led_duty_ramp_checker.sv
tb/sv/breathing_led_duty_ramp_tb.sv
